FILE: src/nlp_pkg.sv
// Shared types and constants for the next lexicographic permutation unit.
`timescale 1ns / 1ps

package nlp_pkg;

   localparam int DEFAULT_MAX_LEN = 8;
   localparam int ELEM_W          = 16;
   // Index and length fields of a queued beat; wide enough for the largest store
   localparam int IDX_W           = 7;
   localparam int QDEPTH          = 4;
   localparam int QPTR_W          = 2;

   typedef struct packed {
      logic [ELEM_W-1:0] elem_value;
      logic [IDX_W-1:0]  addr;
      logic              wen;
      logic              last;
      logic [IDX_W-1:0]  len;
   } nlp_entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_FIND_RD,
      ST_FIND_CMP,
      ST_SWAP1,
      ST_SWAP2,
      ST_REV_RD,
      ST_REV_CMP,
      ST_REV_W2,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } nlp_state_type;

endpackage

FILE: src/nlp_ram.sv
// Generic single-write, dual-read RAM with registered read data.
`timescale 1ns / 1ps

module nlp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

FILE: src/nlp_front.sv
// Front end: accepts input beats, tracks the load count and tags each beat.
`timescale 1ns / 1ps

module nlp_front
   import nlp_pkg::*;
#(
   parameter int MAX_LEN = DEFAULT_MAX_LEN
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [ELEM_W-1:0]   req_elem_value,
   input  logic                req_is_last,
   output logic                push,
   output nlp_entry_type       push_entry,
   input  logic                queue_full
);

   localparam int LW = $clog2(MAX_LEN + 1);

   logic [LW-1:0] count_ff;
   logic [LW-1:0] count_in;
   logic          room;
   logic [LW-1:0] len_now;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;
   assign room      = count_ff < LW'(MAX_LEN);
   assign len_now   = room ? count_ff + 1'b1 : count_ff;

   always_comb begin
      push_entry.elem_value = req_elem_value;
      push_entry.addr       = IDX_W'(count_ff);
      push_entry.wen        = room;
      push_entry.last       = req_is_last;
      push_entry.len        = IDX_W'(len_now);
   end

   // The last beat closes the sequence even when it is dropped
   always_comb begin
      count_in = count_ff;
      if (push) begin
         count_in = req_is_last ? '0 : len_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

FILE: src/nlp_queue.sv
// Short queue of tagged beats between front and back ends.
`timescale 1ns / 1ps

module nlp_queue
   import nlp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  nlp_entry_type push_entry,
   output logic          full,
   input  logic          pop,
   output logic          not_empty,
   output nlp_entry_type head
);

   nlp_entry_type       slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QPTR_W:0]     count_ff;
   logic [QPTR_W:0]     count_in;
   logic                do_pop;

   assign full      = count_ff == (QPTR_W + 1)'(QDEPTH);
   assign not_empty = count_ff != '0;
   assign head      = slot_ff[rd_ptr_ff];
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: src/nlp_back.sv
// Back end: stores elements, permutes them in RAM and emits the result beats.
`timescale 1ns / 1ps

module nlp_back
   import nlp_pkg::*;
#(
   parameter int MAX_LEN = DEFAULT_MAX_LEN
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_not_empty,
   input  nlp_entry_type     q_head,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [ELEM_W-1:0] rsp_out_value,
   output logic              rsp_out_last,
   output logic              rsp_has_next
);

   localparam int AW = $clog2(MAX_LEN);
   localparam int LW = $clog2(MAX_LEN + 1);

   nlp_state_type     state_ff;
   nlp_state_type     state_in;
   logic [LW-1:0]     len_ff;
   logic [LW-1:0]     len_in;
   logic [AW-1:0]     p_ff;
   logic [AW-1:0]     p_in;
   logic [AW-1:0]     piv_ff;
   logic [AW-1:0]     piv_in;
   logic [AW-1:0]     lo_ff;
   logic [AW-1:0]     lo_in;
   logic [AW-1:0]     hi_ff;
   logic [AW-1:0]     hi_in;
   logic [ELEM_W-1:0] pivval_ff;
   logic [ELEM_W-1:0] pivval_in;
   logic [ELEM_W-1:0] tmp_ff;
   logic [ELEM_W-1:0] tmp_in;
   logic              found_ff;
   logic              found_in;
   logic              out_valid_ff;
   logic              out_valid_in;
   logic [ELEM_W-1:0] out_value_ff;
   logic [ELEM_W-1:0] out_value_in;
   logic              out_last_ff;
   logic              out_last_in;
   logic              out_hn_ff;
   logic              out_hn_in;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [ELEM_W-1:0] wr_data;
   logic [AW-1:0]     rd_addr_a;
   logic [AW-1:0]     rd_addr_b;
   logic [ELEM_W-1:0] rd_data_a;
   logic [ELEM_W-1:0] rd_data_b;

   logic [LW-1:0]     len_m1;
   logic [LW-1:0]     head_len;
   logic [LW-1:0]     head_len_m1;
   logic              out_free;
   logic              ascent;
   logic              larger;
   logic              emit_end;

   nlp_ram #(
      .WIDTH (ELEM_W),
      .DEPTH (MAX_LEN)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   assign len_m1      = len_ff - 1'b1;
   assign head_len    = q_head.len[LW-1:0];
   assign head_len_m1 = head_len - 1'b1;
   assign out_free    = !out_valid_ff || !rsp_stall;
   assign ascent      = rd_data_a < rd_data_b;
   assign larger      = rd_data_a > pivval_ff;
   assign emit_end    = p_ff == len_m1[AW-1:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_not_empty && q_head.last) begin
               state_in = (head_len == LW'(1)) ? ST_EMIT_RD : ST_SCAN_RD;
            end
         end
         ST_SCAN_RD:  state_in = ST_SCAN_CMP;
         ST_SCAN_CMP: begin
            if (ascent) begin
               state_in = ST_FIND_RD;
            end else if (p_ff == AW'(1)) begin
               state_in = ST_EMIT_RD;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_FIND_RD:  state_in = ST_FIND_CMP;
         ST_FIND_CMP: state_in = larger ? ST_SWAP1 : ST_FIND_RD;
         ST_SWAP1:    state_in = ST_SWAP2;
         ST_SWAP2:    state_in = ST_REV_RD;
         ST_REV_RD:   state_in = (lo_ff < hi_ff) ? ST_REV_CMP : ST_EMIT_RD;
         ST_REV_CMP:  state_in = ST_REV_W2;
         ST_REV_W2:   state_in = ST_REV_RD;
         ST_EMIT_RD:  state_in = ST_EMIT_OUT;
         ST_EMIT_OUT: begin
            if (out_free) begin
               state_in = emit_end ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // Datapath and RAM controls
   always_comb begin
      len_in       = len_ff;
      p_in         = p_ff;
      piv_in       = piv_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      pivval_in    = pivval_ff;
      tmp_in       = tmp_ff;
      found_in     = found_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      out_hn_in    = out_hn_ff;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = p_ff;
      wr_data      = tmp_ff;
      rd_addr_a    = p_ff;
      rd_addr_b    = p_ff;
      case (state_ff)
         ST_IDLE: begin
            q_pop   = q_not_empty;
            wr_en   = q_not_empty && q_head.wen;
            wr_addr = q_head.addr[AW-1:0];
            wr_data = q_head.elem_value;
            if (q_not_empty && q_head.last) begin
               len_in   = head_len;
               found_in = 1'b0;
               p_in     = (head_len == LW'(1)) ? '0 : head_len_m1[AW-1:0];
            end
         end
         ST_SCAN_RD: begin
            rd_addr_a = p_ff - 1'b1;
         end
         ST_SCAN_CMP: begin
            if (ascent) begin
               piv_in    = p_ff - 1'b1;
               pivval_in = rd_data_a;
               found_in  = 1'b1;
               p_in      = len_m1[AW-1:0];
            end else if (p_ff == AW'(1)) begin
               p_in = '0;
            end else begin
               p_in = p_ff - 1'b1;
            end
         end
         ST_FIND_CMP: begin
            if (larger) begin
               tmp_in = rd_data_a;
            end else begin
               p_in = p_ff - 1'b1;
            end
         end
         ST_SWAP1: begin
            wr_en   = 1'b1;
            wr_addr = piv_ff;
            wr_data = tmp_ff;
         end
         ST_SWAP2: begin
            wr_en   = 1'b1;
            wr_addr = p_ff;
            wr_data = pivval_ff;
            lo_in   = piv_ff + 1'b1;
            hi_in   = len_m1[AW-1:0];
         end
         ST_REV_RD: begin
            rd_addr_a = lo_ff;
            rd_addr_b = hi_ff;
            if (!(lo_ff < hi_ff)) begin
               p_in = '0;
            end
         end
         ST_REV_CMP: begin
            wr_en   = 1'b1;
            wr_addr = lo_ff;
            wr_data = rd_data_b;
            tmp_in  = rd_data_a;
         end
         ST_REV_W2: begin
            wr_en   = 1'b1;
            wr_addr = hi_ff;
            wr_data = tmp_ff;
            lo_in   = lo_ff + 1'b1;
            hi_in   = hi_ff - 1'b1;
         end
         ST_EMIT_OUT: begin
            // Keep reading the same entry while the output register is held
            if (out_free) begin
               out_valid_in = 1'b1;
               out_value_in = rd_data_a;
               out_last_in  = emit_end;
               out_hn_in    = found_ff;
               if (!emit_end) begin
                  p_in = p_ff + 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff       <= len_in;
      p_ff         <= p_in;
      piv_ff       <= piv_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      pivval_ff    <= pivval_in;
      tmp_ff       <= tmp_in;
      found_ff     <= found_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
      out_hn_ff    <= out_hn_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_value = out_value_ff;
   assign rsp_out_last  = out_last_ff;
   assign rsp_has_next  = out_hn_ff;

endmodule

FILE: src/next_lexicographic_permutation_unit.sv
// Input beats enter a four-beat queue at one per cycle while it has room; the back end writes one
// per cycle while idle. After the last beat of an L-element sequence, each pivot-scan and search
// step reads then compares, the swap writes in SWAP1 and SWAP2, each reversal pair takes REV_RD,
// REV_CMP and REV_W2, and each element is emitted by EMIT_RD then EMIT_OUT; one RAM write port.
// Reset is synchronous: it clears the load count, the queue, the sequencer and the output valid;
// the element store is not cleared.
`timescale 1ns / 1ps

module next_lexicographic_permutation_unit
   import nlp_pkg::*;
#(
   parameter int MAX_LEN = DEFAULT_MAX_LEN
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [ELEM_W-1:0] req_elem_value,
   input  logic              req_is_last,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [ELEM_W-1:0] rsp_out_value,
   output logic              rsp_out_last,
   output logic              rsp_has_next
);

   logic          push;
   nlp_entry_type push_entry;
   logic          queue_full;
   logic          q_pop;
   logic          q_not_empty;
   nlp_entry_type q_head;

   nlp_front #(
      .MAX_LEN (MAX_LEN)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_elem_value (req_elem_value),
      .req_is_last    (req_is_last),
      .push           (push),
      .push_entry     (push_entry),
      .queue_full     (queue_full)
   );

   nlp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   nlp_back #(
      .MAX_LEN (MAX_LEN)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_not_empty   (q_not_empty),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_value (rsp_out_value),
      .rsp_out_last  (rsp_out_last),
      .rsp_has_next  (rsp_has_next)
   );

endmodule

FILE: src/nlp_checker.sv
// Port-level checks on the result channel, bound to the top level.
`timescale 1ns / 1ps

module nlp_checker
   import nlp_pkg::*;
#(
   parameter int MAX_LEN = DEFAULT_MAX_LEN
) (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [ELEM_W-1:0] rsp_out_value,
   input logic              rsp_out_last,
   input logic              rsp_has_next
);

   localparam int CW = $clog2(MAX_LEN);

   logic          rsp_beat;
   logic [CW-1:0] beat_cnt_ff;
   logic [CW-1:0] beat_cnt_in;
   logic          hn_ff;
   logic          hn_in;

   assign rsp_beat = rsp_valid && !rsp_stall;

   // Count beats within the sequence being emitted
   always_comb begin
      beat_cnt_in = beat_cnt_ff;
      hn_in       = hn_ff;
      if (rsp_beat) begin
         beat_cnt_in = rsp_out_last ? '0 : beat_cnt_ff + 1'b1;
         hn_in       = rsp_has_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_cnt_ff <= '0;
         hn_ff       <= 1'b0;
      end else begin
         beat_cnt_ff <= beat_cnt_in;
         hn_ff       <= hn_in;
      end
   end

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_value)
         && $stable(rsp_out_last) && $stable(rsp_has_next))
      else $error("stalled result beat changed");

   a_flag_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && beat_cnt_ff != '0 |-> rsp_has_next == hn_ff)
      else $error("next-permutation flag changed within a sequence");

   a_max_len: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && beat_cnt_ff == CW'(MAX_LEN - 1) |-> rsp_out_last)
      else $error("sequence longer than the store");

   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && beat_cnt_ff == '0 && rsp_out_last |-> !rsp_has_next)
      else $error("single element reported as permutable");

endmodule

bind next_lexicographic_permutation_unit nlp_checker #(.MAX_LEN(MAX_LEN)) u_checker (.*);

FILE: tb/sv/nlp_perm_checker.sv
// Checker for the permutation unit: predicts each output sequence and compares every result beat.
`timescale 1ns / 1ps

module nlp_perm_checker
   import nlp_pkg::*;
#(
   parameter int MAX_LEN = DEFAULT_MAX_LEN
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [ELEM_W-1:0] req_elem_value,
   input  logic              req_is_last,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [ELEM_W-1:0] rsp_out_value,
   input  logic              rsp_out_last,
   input  logic              rsp_has_next,
   output int                mismatch_count,
   output int                beats_owed
);

   typedef struct packed {
      logic [ELEM_W-1:0] value;
      logic              last;
      logic              has_next;
   } perm_beat_type;

   logic [ELEM_W-1:0] stored [MAX_LEN];
   int                stored_count;
   perm_beat_type     owed_beats [$];

   initial begin
      mismatch_count = 0;
      beats_owed     = 0;
      stored_count   = 0;
   end

   // Rewrite stored[0..len-1] into its next arrangement; report whether one exists.
   function automatic bit step_to_next_arrangement(input int len);
      int                piv;
      int                k;
      int                lo;
      int                hi;
      logic [ELEM_W-1:0] held;
      if (len < 2) return 1'b0;
      piv = len - 1;
      while (piv > 0 && stored[piv-1] >= stored[piv]) piv--;
      if (piv == 0) return 1'b0;
      piv--;
      k = len - 1;
      while (stored[k] <= stored[piv]) k--;
      held        = stored[piv];
      stored[piv] = stored[k];
      stored[k]   = held;
      lo = piv + 1;
      hi = len - 1;
      while (lo < hi) begin
         held       = stored[lo];
         stored[lo] = stored[hi];
         stored[hi] = held;
         lo++;
         hi--;
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin : watch
      int            len;
      bit            found;
      perm_beat_type want;
      if (reset) begin
         stored_count = 0;
         owed_beats.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_beats.size() == 0) begin
               $display({"%0t: result beat with none owed: expected nothing, ",
                         "actual %h last %b next %b"},
                        $time, rsp_out_value, rsp_out_last, rsp_has_next);
               mismatch_count++;
            end else begin
               want = owed_beats.pop_front();
               if (rsp_out_value !== want.value) begin
                  $display("%0t: out_value expected %h actual %h",
                           $time, want.value, rsp_out_value);
                  mismatch_count++;
               end
               if (rsp_out_last !== want.last) begin
                  $display("%0t: out_last expected %b actual %b",
                           $time, want.last, rsp_out_last);
                  mismatch_count++;
               end
               if (rsp_has_next !== want.has_next) begin
                  $display("%0t: has_next expected %b actual %b",
                           $time, want.has_next, rsp_has_next);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            // drop elements past the end of the store
            if (stored_count < MAX_LEN) begin
               stored[stored_count] = req_elem_value;
               stored_count++;
            end
            if (req_is_last) begin
               len   = stored_count;
               found = step_to_next_arrangement(len);
               for (int i = 0; i < len; i++) begin
                  want.value    = stored[i];
                  want.last     = (i + 1 == len);
                  want.has_next = found;
                  owed_beats.push_back(want);
               end
               stored_count = 0;
            end
         end
      end
      beats_owed = owed_beats.size();
   end

endmodule

FILE: tb/sv/tb_top.sv
// Top of the permutation unit testbench: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb_top;
   import nlp_pkg::*;

   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              req_valid      = 1'b0;
   logic              req_stall;
   logic [ELEM_W-1:0] req_elem_value = '0;
   logic              req_is_last    = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall      = 1'b0;
   logic [ELEM_W-1:0] rsp_out_value;
   logic              rsp_out_last;
   logic              rsp_has_next;

   int                mismatch_count;
   int                beats_owed;
   bit                idle_en    = 1'b1;
   int                stall_left = 0;
   int                items_sent = 0;
   logic [ELEM_W-1:0] seq_vals [$];

   next_lexicographic_permutation_unit #(.MAX_LEN(DEFAULT_MAX_LEN)) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_elem_value (req_elem_value),
      .req_is_last    (req_is_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_value  (rsp_out_value),
      .rsp_out_last   (rsp_out_last),
      .rsp_has_next   (rsp_has_next)
   );

   nlp_perm_checker #(.MAX_LEN(DEFAULT_MAX_LEN)) perm_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_elem_value (req_elem_value),
      .req_is_last    (req_is_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_value  (rsp_out_value),
      .rsp_out_last   (rsp_out_last),
      .rsp_has_next   (rsp_has_next),
      .mismatch_count (mismatch_count),
      .beats_owed     (beats_owed)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb_top: errors");
      $finish;
   end

   // Receiver back-pressure in random bursts
   always @(negedge clock) begin
      if (!idle_en) begin
         stall_left = 0;
         rsp_stall  = 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall = 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 16) - 1;
         rsp_stall  = 1'b1;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   // Offer one beat, possibly after a gap, and hold it until taken.
   task send_beat(input logic [ELEM_W-1:0] value, input logic last);
      int gap;
      if (idle_en && $urandom_range(0, 3) == 0) begin
         gap       = $urandom_range(1, 16);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      = 1'b1;
      req_elem_value = value;
      req_is_last    = last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task send_sequence();
      for (int i = 0; i < seq_vals.size(); i++)
         send_beat(seq_vals[i], i == seq_vals.size() - 1);
   endtask

   initial begin
      int len;
      int mode;
      int pick;
      logic [ELEM_W-1:0] fill;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // single element, ascent at the extremes, descent, equal pair
      seq_vals = '{16'hFFFF};
      send_sequence();
      seq_vals = '{16'h0000, 16'hFFFF};
      send_sequence();
      seq_vals = '{16'hFFFF, 16'h0000};
      send_sequence();
      seq_vals = '{16'h0005, 16'h0005};
      send_sequence();
      // repeated values: only a strictly larger element swaps in
      seq_vals = '{16'h0001, 16'h0003, 16'h0003, 16'h0002};
      send_sequence();
      // overlong: extras dropped, the last flag still closes the sequence
      seq_vals = '{16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0005,
                   16'h0006, 16'h0007, 16'h0008, 16'hAAAA, 16'h5555};
      send_sequence();
      seq_vals = '{16'h0002, 16'h0001, 16'h0002};
      send_sequence();

      while (items_sent < 260) begin
         // quiet final stretch, and some quiet sequences before it
         idle_en = (items_sent < 200) && ($urandom_range(0, 4) != 0);
         pick = $urandom_range(0, 9);
         len  = (pick == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
         mode = $urandom_range(0, 5);
         fill = ELEM_W'($urandom_range(0, 16'hFFFF));
         seq_vals.delete();
         for (int i = 0; i < len; i++) begin
            case (mode)
               0, 1:    seq_vals.push_back(ELEM_W'($urandom_range(0, 3)));
               2:       seq_vals.push_back(ELEM_W'($urandom_range(0, 15)));
               5:       seq_vals.push_back(fill);
               default: seq_vals.push_back(ELEM_W'($urandom_range(0, 16'hFFFF)));
            endcase
         end
         // non-increasing: no next arrangement
         if (mode == 4) seq_vals.rsort();
         send_sequence();
      end

      req_valid   = 1'b0;
      req_is_last = 1'b0;
      while (beats_owed != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

FILE: filelist.f
src/nlp_pkg.sv
src/nlp_ram.sv
src/nlp_front.sv
src/nlp_queue.sv
src/nlp_back.sv
src/next_lexicographic_permutation_unit.sv
src/nlp_checker.sv
tb/sv/nlp_perm_checker.sv
tb/sv/tb_top.sv
